// ----- hw/rtl/swt_pkg.sv -----
// ----------------------------------------------------------------------------
// swt_pkg: shared types and constants of the shell word tokenizer
// Scan modes, quote states, byte classes, error codes and the payload
// structs of the input, the output and the internal queue.
// ----------------------------------------------------------------------------
package swt_pkg;

    localparam int DEF_MAX_NESTING   = 255;
    localparam int DEF_POSITION_BITS = 16;
    localparam int DEF_QUEUE_DEPTH   = 2;

    localparam int CHAR_W  = 8;
    localparam int POSN_W  = 16;
    localparam int CODE_W  = 3;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    typedef enum logic [2:0] {
        MODE_TOP   = 3'd0,
        MODE_CMD   = 3'd1,
        MODE_BRACE = 3'd2,
        MODE_TICK  = 3'd3,
        MODE_DSQ   = 3'd4
    } mode_t;

    typedef enum logic [1:0] {
        Q_NONE   = 2'd0,
        Q_SINGLE = 2'd1,
        Q_DOUBLE = 2'd2
    } quote_t;

    typedef enum logic [3:0] {
        CLS_OTHER,
        CLS_SPACE,
        CLS_NEWLINE,
        CLS_DOLLAR,
        CLS_LPAREN,
        CLS_RPAREN,
        CLS_LBRACE,
        CLS_RBRACE,
        CLS_TICK,
        CLS_BSLASH,
        CLS_SQUOTE,
        CLS_DQUOTE
    } cls_t;

    localparam logic [CODE_W-1:0] ERR_NONE   = 3'd0;
    localparam logic [CODE_W-1:0] ERR_CMD    = 3'd1;
    localparam logic [CODE_W-1:0] ERR_TICK   = 3'd2;
    localparam logic [CODE_W-1:0] ERR_DSQ    = 3'd3;
    localparam logic [CODE_W-1:0] ERR_PARAM  = 3'd4;
    localparam logic [CODE_W-1:0] ERR_BSLASH = 3'd5;
    localparam logic [CODE_W-1:0] ERR_QUOTE  = 3'd6;
    localparam logic [CODE_W-1:0] ERR_NEST   = 3'd7;

    typedef struct packed {
        logic [CHAR_W-1:0] char_in;
        logic              is_end;
    } swt_in_t;

    typedef struct packed {
        logic [CHAR_W-1:0] char_out;
        logic              char_valid;
        logic              word_end;
        logic [CODE_W-1:0] error_code;
        logic [POSN_W-1:0] error_line;
        logic [POSN_W-1:0] error_column;
        logic              line_done;
    } swt_out_t;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              is_end;
        cls_t              cls;
    } swt_entry_t;

    typedef struct packed {
        logic       valid;
        swt_entry_t entry;
    } swt_qhead_t;

endpackage

// ----- hw/rtl/swt_front.sv -----
// ----------------------------------------------------------------------------
// swt_front: input side of the tokenizer
// Takes input transfers while the queue has room and tags each byte with
// its class, so the back end decides on small class codes, not raw bytes.
// ----------------------------------------------------------------------------
module swt_front (
    input  logic             in_valid,
    output logic             in_ready,
    input  swt_pkg::swt_in_t in_data,
    input  logic             q_full,
    output logic             q_wr,
    output swt_pkg::swt_entry_t q_entry
);
    import swt_pkg::*;

    localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
    localparam logic [CHAR_W-1:0] CH_TAB     = 8'h09;
    localparam logic [CHAR_W-1:0] CH_NL      = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_VT      = 8'h0B;
    localparam logic [CHAR_W-1:0] CH_FF      = 8'h0C;
    localparam logic [CHAR_W-1:0] CH_CR      = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_DOLLAR  = 8'h24;
    localparam logic [CHAR_W-1:0] CH_LPAREN  = 8'h28;
    localparam logic [CHAR_W-1:0] CH_RPAREN  = 8'h29;
    localparam logic [CHAR_W-1:0] CH_LBRACE  = 8'h7B;
    localparam logic [CHAR_W-1:0] CH_RBRACE  = 8'h7D;
    localparam logic [CHAR_W-1:0] CH_TICK    = 8'h60;
    localparam logic [CHAR_W-1:0] CH_BSLASH  = 8'h5C;
    localparam logic [CHAR_W-1:0] CH_SQUOTE  = 8'h27;
    localparam logic [CHAR_W-1:0] CH_DQUOTE  = 8'h22;

    function automatic cls_t classify(input logic [CHAR_W-1:0] c);
        cls_t k;
        case (c)
            CH_SPACE, CH_TAB, CH_VT, CH_FF, CH_CR: k = CLS_SPACE;
            CH_NL:     k = CLS_NEWLINE;
            CH_DOLLAR: k = CLS_DOLLAR;
            CH_LPAREN: k = CLS_LPAREN;
            CH_RPAREN: k = CLS_RPAREN;
            CH_LBRACE: k = CLS_LBRACE;
            CH_RBRACE: k = CLS_RBRACE;
            CH_TICK:   k = CLS_TICK;
            CH_BSLASH: k = CLS_BSLASH;
            CH_SQUOTE: k = CLS_SQUOTE;
            CH_DQUOTE: k = CLS_DQUOTE;
            default:   k = CLS_OTHER;
        endcase
        return k;
    endfunction

    assign in_ready       = !q_full;
    assign q_wr           = in_valid && !q_full;
    assign q_entry.ch     = in_data.char_in;
    assign q_entry.is_end = in_data.is_end;
    assign q_entry.cls    = classify(in_data.char_in);

endmodule

// ----- hw/rtl/swt_queue.sv -----
// ----------------------------------------------------------------------------
// swt_queue: short FIFO between front and back
// Holds classified bytes so that the input side and the tokenizer stall
// independently of each other.
// ----------------------------------------------------------------------------
module swt_queue #(
    parameter int DEPTH = swt_pkg::DEF_QUEUE_DEPTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr,
    input  swt_pkg::swt_entry_t wr_entry,
    output logic                full,
    input  logic                pop,
    output swt_pkg::swt_qhead_t head
);
    import swt_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    swt_entry_t           slot_reg [DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic                 do_pop;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign full        = (count_reg == CNT_W'(DEPTH));
    assign head.valid  = (count_reg != '0);
    assign head.entry  = slot_reg[rd_ptr_reg];
    assign do_pop      = pop && head.valid;

    always_comb
    begin
        wr_ptr_next = wr ? bump(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = do_pop ? bump(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (wr && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_entry;
        end
    end

endmodule

// ----- hw/rtl/swt_back.sv -----
// ----------------------------------------------------------------------------
// swt_back: tokenizer state machine and output register
// Updates the scan state for one byte per cycle while the output register
// can take a result, tracks the error position and drives the result register toward the output channel.
// ----------------------------------------------------------------------------
module swt_back #(
    parameter int MAX_NESTING   = swt_pkg::DEF_MAX_NESTING,
    parameter int POSITION_BITS = swt_pkg::DEF_POSITION_BITS
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  swt_pkg::swt_qhead_t       head,
    output logic                      pop,
    input  logic [swt_pkg::POSN_W-1:0] start_line,
    output logic                      out_valid,
    input  logic                      out_ready,
    output swt_pkg::swt_out_t         out_data
);
    import swt_pkg::*;

    localparam int POS_W = (POSITION_BITS < POSN_W) ? POSITION_BITS : POSN_W;
    localparam int DEP_W = $clog2(MAX_NESTING + 1);
    localparam logic [POS_W-1:0] POS_LIM = '1;
    localparam logic [POS_W:0]   COL_LIM = {1'b0, POS_LIM};
    localparam logic [DEP_W-1:0] DEP_MAX = DEP_W'(MAX_NESTING);

    mode_t            mode_reg, mode_next;
    quote_t           outer_reg, outer_next;
    quote_t           inner_reg, inner_next;
    logic             escape_reg, escape_next;
    logic             dollar_reg, dollar_next;
    logic [DEP_W-1:0] depth_reg, depth_next;
    logic             word_reg, word_next;
    logic             latched_reg, latched_next;
    logic [POS_W-1:0] line_reg, line_next;
    logic [POS_W:0]   col_reg, col_next;
    logic             out_valid_reg, out_valid_next;
    swt_out_t         out_data_reg;

    logic              keep, brk, done, step_pos, top_path, is_ws, is_cmd;
    logic [CODE_W-1:0] err_code;
    logic [POS_W:0]    err_col;
    logic [DEP_W-1:0]  dep_dec;
    cls_t              cls_open, cls_close;
    logic [POSN_W-1:0] first_line;
    logic [POSN_W:0]   line_sum;
    logic [POS_W-1:0]  line_cap, col_cap;
    swt_out_t          res;

    swt_entry_t e;
    assign e   = head.entry;
    assign pop = head.valid && (!out_valid_reg || out_ready);

    // Next scan state for the byte at the queue head.
    always_comb
    begin
        mode_next    = mode_reg;
        outer_next   = outer_reg;
        inner_next   = inner_reg;
        escape_next  = escape_reg;
        dollar_next  = dollar_reg;
        depth_next   = depth_reg;
        word_next    = word_reg;
        latched_next = latched_reg;
        line_next    = line_reg;
        col_next     = col_reg;
        keep         = 1'b0;
        brk          = 1'b0;
        done         = 1'b0;
        step_pos     = 1'b0;
        top_path     = 1'b0;
        err_code     = ERR_NONE;
        err_col      = col_reg;
        is_ws        = (e.cls == CLS_SPACE) || (e.cls == CLS_NEWLINE);
        is_cmd       = (mode_reg == MODE_CMD);
        cls_open     = is_cmd ? CLS_LPAREN : CLS_LBRACE;
        cls_close    = is_cmd ? CLS_RPAREN : CLS_RBRACE;
        dep_dec      = (depth_reg != '0) ? depth_reg - 1'b1 : depth_reg;

        if (e.is_end)
        begin
            done = 1'b1;
            if (!latched_reg)
            begin
                case (mode_reg)
                    MODE_CMD:   err_code = ERR_CMD;
                    MODE_TICK:  err_code = ERR_TICK;
                    MODE_DSQ:   err_code = ERR_DSQ;
                    MODE_BRACE: err_code = ERR_PARAM;
                    default:
                    begin
                        if (escape_reg)
                        begin
                            // The backslash itself is the reported position.
                            err_code = ERR_BSLASH;
                            err_col  = col_reg - 1'b1;
                        end
                        else if (outer_reg != Q_NONE)
                        begin
                            err_code = ERR_QUOTE;
                        end
                    end
                endcase
                brk = word_reg && (err_code == ERR_NONE);
            end
            mode_next    = MODE_TOP;
            outer_next   = Q_NONE;
            inner_next   = Q_NONE;
            escape_next  = 1'b0;
            dollar_next  = 1'b0;
            depth_next   = '0;
            word_next    = 1'b0;
            latched_next = 1'b0;
            line_next    = '0;
            col_next     = (POS_W + 1)'(1);
        end
        else if (!latched_reg)
        begin
            step_pos = 1'b1;
            if (escape_reg)
            begin
                escape_next = 1'b0;
                keep        = 1'b1;
            end
            else if (mode_reg == MODE_TOP)
            begin
                if (dollar_reg)
                begin
                    dollar_next = 1'b0;
                    if (e.cls == CLS_LPAREN || e.cls == CLS_LBRACE)
                    begin
                        mode_next  = (e.cls == CLS_LPAREN) ? MODE_CMD : MODE_BRACE;
                        depth_next = DEP_W'(1);
                        inner_next = Q_NONE;
                        keep       = 1'b1;
                    end
                    else if (e.cls == CLS_SQUOTE)
                    begin
                        mode_next = MODE_DSQ;
                        keep      = 1'b1;
                    end
                    else
                    begin
                        top_path = 1'b1;
                    end
                end
                else
                begin
                    top_path = 1'b1;
                end
            end
            else if (mode_reg == MODE_CMD || mode_reg == MODE_BRACE)
            begin
                keep = 1'b1;
                case (inner_reg)
                    Q_NONE:
                    begin
                        if (e.cls == CLS_BSLASH)
                        begin
                            escape_next = 1'b1;
                        end
                        else if (e.cls == CLS_DQUOTE)
                        begin
                            inner_next = Q_DOUBLE;
                        end
                        else if (e.cls == CLS_SQUOTE && (is_cmd || outer_reg != Q_DOUBLE))
                        begin
                            inner_next = Q_SINGLE;
                        end
                        else if (e.cls == cls_open)
                        begin
                            if (depth_reg >= DEP_MAX)
                            begin
                                // Overflow: the byte is dropped and the position holds.
                                keep         = 1'b0;
                                step_pos     = 1'b0;
                                err_code     = ERR_NEST;
                                latched_next = 1'b1;
                            end
                            else
                            begin
                                depth_next = depth_reg + 1'b1;
                            end
                        end
                        else if (e.cls == cls_close)
                        begin
                            depth_next = dep_dec;
                            if (dep_dec == '0)
                            begin
                                mode_next = MODE_TOP;
                            end
                        end
                    end
                    Q_SINGLE:
                    begin
                        if (e.cls == CLS_SQUOTE)
                        begin
                            inner_next = Q_NONE;
                        end
                    end
                    default:
                    begin
                        if (e.cls == CLS_BSLASH)
                        begin
                            escape_next = 1'b1;
                        end
                        else if (e.cls == CLS_DQUOTE)
                        begin
                            inner_next = Q_NONE;
                        end
                    end
                endcase
            end
            else
            begin
                keep = 1'b1;
                if (e.cls == CLS_BSLASH)
                begin
                    escape_next = 1'b1;
                end
                else if ((mode_reg == MODE_TICK && e.cls == CLS_TICK) ||
                         (mode_reg == MODE_DSQ && e.cls == CLS_SQUOTE))
                begin
                    mode_next = MODE_TOP;
                end
            end

            if (top_path)
            begin
                if (outer_reg == Q_NONE && is_ws)
                begin
                    brk       = word_reg;
                    word_next = 1'b0;
                end
                else
                begin
                    word_next = 1'b1;
                    keep      = 1'b1;
                    if (outer_reg != Q_SINGLE && e.cls == CLS_DOLLAR)
                    begin
                        dollar_next = 1'b1;
                    end
                    else if (outer_reg != Q_SINGLE && e.cls == CLS_TICK)
                    begin
                        mode_next = MODE_TICK;
                    end
                    else if (e.cls == CLS_SQUOTE && outer_reg != Q_DOUBLE)
                    begin
                        outer_next = (outer_reg == Q_NONE) ? Q_SINGLE : Q_NONE;
                    end
                    else if (e.cls == CLS_DQUOTE && outer_reg != Q_SINGLE)
                    begin
                        outer_next = (outer_reg == Q_NONE) ? Q_DOUBLE : Q_NONE;
                    end
                    else if (e.cls == CLS_BSLASH && outer_reg != Q_SINGLE)
                    begin
                        escape_next = 1'b1;
                    end
                end
            end

            if (step_pos)
            begin
                if (e.cls == CLS_NEWLINE)
                begin
                    if (line_reg != POS_LIM)
                    begin
                        line_next = line_reg + 1'b1;
                    end
                    col_next = (POS_W + 1)'(1);
                end
                else if (col_reg <= COL_LIM)
                begin
                    col_next = col_reg + 1'b1;
                end
            end
        end
    end

    // Result fields for the byte at the queue head.
    always_comb
    begin
        first_line = (start_line == '0) ? POSN_W'(1) : start_line;
        line_sum   = (POSN_W + 1)'(first_line) + (POSN_W + 1)'(line_reg);
        line_cap   = (line_sum > (POSN_W + 1)'(POS_LIM)) ? POS_LIM : POS_W'(line_sum);
        col_cap    = err_col[POS_W] ? POS_LIM : err_col[POS_W-1:0];

        res.char_out     = keep ? e.ch : '0;
        res.char_valid   = keep;
        res.word_end     = brk;
        res.error_code   = err_code;
        res.error_line   = (err_code != ERR_NONE) ? POSN_W'(line_cap) : '0;
        res.error_column = (err_code != ERR_NONE) ? POSN_W'(col_cap) : '0;
        res.line_done    = done;

        out_valid_next = pop ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_TOP;
            outer_reg     <= Q_NONE;
            inner_reg     <= Q_NONE;
            escape_reg    <= 1'b0;
            dollar_reg    <= 1'b0;
            depth_reg     <= '0;
            word_reg      <= 1'b0;
            latched_reg   <= 1'b0;
            line_reg      <= '0;
            col_reg       <= (POS_W + 1)'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (pop)
            begin
                mode_reg    <= mode_next;
                outer_reg   <= outer_next;
                inner_reg   <= inner_next;
                escape_reg  <= escape_next;
                dollar_reg  <= dollar_next;
                depth_reg   <= depth_next;
                word_reg    <= word_next;
                latched_reg <= latched_next;
                line_reg    <= line_next;
                col_reg     <= col_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_data_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ----- hw/rtl/shell_word_tokenizer.sv -----
// ----------------------------------------------------------------------------
// shell_word_tokenizer: splits a command line into shell words
// Top level with the register port, the classifying front end, the queue
// and the tokenizer back end.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel carries one byte of the command line per transfer;
//   a transfer with is_end set closes the line. The output channel returns
//   exactly one result per input transfer, in order: the kept byte, a
//   word-end mark, an error code with its line and column, and line_done
//   on the end marker.
//   An input transfer is registered in the queue, and its result in the
//   output register of the back end. Throughput is one byte per cycle while
//   the receiver takes results; a stall on out_ready holds it.
//   The register start_line (byte address 0) gives the number of the first
//   line in error reports; write it only while the block is idle.
//   Reset empties the queue, clears the scan state and sets start_line to 1.
//   When the receiver stalls, the result waits in the output register, the
//   queue fills with up to QUEUE_DEPTH bytes and then in_ready drops.
// ----------------------------------------------------------------------------
module shell_word_tokenizer #(
    parameter int MAX_NESTING   = swt_pkg::DEF_MAX_NESTING,
    parameter int POSITION_BITS = swt_pkg::DEF_POSITION_BITS,
    parameter int QUEUE_DEPTH   = swt_pkg::DEF_QUEUE_DEPTH
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  swt_pkg::swt_in_t            in_data,
    output logic                        out_valid,
    input  logic                        out_ready,
    output swt_pkg::swt_out_t           out_data,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [swt_pkg::PADDR_W-1:0] paddr,
    input  logic [swt_pkg::PDATA_W-1:0] pwdata,
    output logic [swt_pkg::PDATA_W-1:0] prdata,
    output logic                        pready
);
    import swt_pkg::*;

    localparam logic REG_START_LINE = 1'b0;

    logic [POSN_W-1:0] start_line_reg;
    logic              cfg_wr;
    logic              q_full, q_wr, q_pop;
    swt_entry_t        q_entry;
    swt_qhead_t        q_head;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[PADDR_W-1:2] == REG_START_LINE) ? PDATA_W'(start_line_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_line_reg <= POSN_W'(1);
        end
        else if (cfg_wr && paddr[PADDR_W-1:2] == REG_START_LINE)
        begin
            start_line_reg <= pwdata[POSN_W-1:0];
        end
    end

    swt_front u_front (
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .q_full   (q_full),
        .q_wr     (q_wr),
        .q_entry  (q_entry)
    );

    swt_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (q_wr),
        .wr_entry (q_entry),
        .full     (q_full),
        .pop      (q_pop),
        .head     (q_head)
    );

    swt_back #(
        .MAX_NESTING   (MAX_NESTING),
        .POSITION_BITS (POSITION_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (q_head),
        .pop        (q_pop),
        .start_line (start_line_reg),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

endmodule

// ----- hw/rtl/swt_checker.sv -----
// ----------------------------------------------------------------------------
// swt_checker: port-level checks of the shell word tokenizer
// Watches the output channel and the consistency of the result fields.
// ----------------------------------------------------------------------------
module swt_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              out_valid,
    input logic              out_ready,
    input swt_pkg::swt_out_t out_data
);
    import swt_pkg::*;

    // A stalled result transfer keeps its contents.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    a_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.error_code == ERR_NONE |->
        out_data.error_line == '0 && out_data.error_column == '0)
        else $error("error position without an error");

    a_kept_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.char_valid |->
        out_data.error_code == ERR_NONE && !out_data.line_done)
        else $error("kept byte on an error or end result");

    a_err_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.error_code != ERR_NONE |->
        !out_data.word_end && out_data.error_line != '0 && out_data.error_column != '0)
        else $error("error result carries a word end or a zero position");

endmodule

bind shell_word_tokenizer swt_checker u_swt_checker (.*);

// ----- test/tokenizer_tb_pkg.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tokenizer_tb_pkg: byte constants and scoreboard of the word tokenizer bench
// The scoreboard keeps its own copy of the scan state, predicts one result
// for every accepted input transfer and compares the results in order.
// ----------------------------------------------------------------------------
package tokenizer_tb_pkg;

    import swt_pkg::*;

    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0a;
    localparam logic [7:0] CH_VT     = 8'h0b;
    localparam logic [7:0] CH_FF     = 8'h0c;
    localparam logic [7:0] CH_CR     = 8'h0d;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_LBRACE = 8'h7b;
    localparam logic [7:0] CH_RBRACE = 8'h7d;
    localparam logic [7:0] CH_TICK   = 8'h60;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;

    localparam logic [PADDR_W-1:0] ADDR_START_LINE = '0;

    localparam int unsigned POS_LIMIT =
        (DEF_POSITION_BITS >= 16) ? 65535 : (1 << DEF_POSITION_BITS) - 1;
    localparam int unsigned MAX_DEPTH = DEF_MAX_NESTING;

    class tokenizer_scoreboard;

        swt_out_t    expected_tokens[$];
        logic [15:0] start_line;
        mode_t       mode;
        quote_t      outer_q;
        quote_t      inner_q;
        bit          esc;
        bit          dol;
        bit          word_act;
        bit          err_lat;
        int unsigned depth;
        int unsigned line_cnt;
        int unsigned col_cnt;

        int unsigned mismatches;
        int unsigned items;
        int unsigned lines;
        int unsigned results;
        int unsigned error_reports;

        function new();
            start_line    = 16'd1;
            mismatches    = 0;
            items         = 0;
            lines         = 0;
            results       = 0;
            error_reports = 0;
            clear_scan();
        endfunction

        function void clear_scan();
            mode     = MODE_TOP;
            outer_q  = Q_NONE;
            inner_q  = Q_NONE;
            esc      = 1'b0;
            dol      = 1'b0;
            word_act = 1'b0;
            err_lat  = 1'b0;
            depth    = 0;
            line_cnt = 0;
            col_cnt  = 1;
        endfunction

        function void set_start_line(logic [15:0] value);
            start_line = value;
        endfunction

        function int unsigned pending();
            return expected_tokens.size();
        endfunction

        function int unsigned cap_pos(int unsigned v);
            return (v > POS_LIMIT) ? POS_LIMIT : v;
        endfunction

        function bit is_blank(logic [7:0] c);
            return c == CH_SPACE || c == CH_TAB || c == CH_NL || c == CH_VT ||
                   c == CH_FF || c == CH_CR;
        endfunction

        function void flag_error(inout swt_out_t r, input logic [CODE_W-1:0] code,
                                 input int unsigned col);
            int unsigned base;
            base           = (start_line == 16'd0) ? 1 : 32'(start_line);
            r.char_valid   = 1'b0;
            r.word_end     = 1'b0;
            r.error_code   = code;
            r.error_line   = 16'(cap_pos(base + line_cnt));
            r.error_column = 16'(cap_pos(col));
            err_lat        = 1'b1;
        endfunction

        function void advance_pos(logic [7:0] c);
            if (c == CH_NL) begin
                if (line_cnt < POS_LIMIT)
                    line_cnt++;
                col_cnt = 1;
            end else if (col_cnt <= POS_LIMIT) begin
                col_cnt++;
            end
        endfunction

        // Byte at top level, outside any substitution. Returns 1 if it is kept.
        function bit top_byte(logic [7:0] c, inout bit brk);
            if (outer_q == Q_NONE && is_blank(c)) begin
                if (word_act) begin
                    brk      = 1'b1;
                    word_act = 1'b0;
                end
                return 1'b0;
            end
            word_act = 1'b1;
            if (outer_q != Q_SINGLE && c == CH_DOLLAR)
                dol = 1'b1;
            else if (outer_q != Q_SINGLE && c == CH_TICK)
                mode = MODE_TICK;
            else if (c == CH_SQUOTE && outer_q != Q_DOUBLE)
                outer_q = (outer_q == Q_NONE) ? Q_SINGLE : Q_NONE;
            else if (c == CH_DQUOTE && outer_q != Q_SINGLE)
                outer_q = (outer_q == Q_NONE) ? Q_DOUBLE : Q_NONE;
            else if (c == CH_BSLASH && outer_q != Q_SINGLE)
                esc = 1'b1;
            return 1'b1;
        endfunction

        // Byte inside a command or parameter substitution.
        // Returns 0 when an opening bracket would overflow the nesting limit.
        function bit nest_byte(logic [7:0] c);
            logic [7:0] open_ch;
            logic [7:0] close_ch;
            open_ch  = (mode == MODE_CMD) ? CH_LPAREN : CH_LBRACE;
            close_ch = (mode == MODE_CMD) ? CH_RPAREN : CH_RBRACE;
            if (inner_q == Q_NONE) begin
                if (c == CH_BSLASH) begin
                    esc = 1'b1;
                end else if (c == CH_DQUOTE) begin
                    inner_q = Q_DOUBLE;
                end else if (c == CH_SQUOTE && (mode == MODE_CMD || outer_q != Q_DOUBLE)) begin
                    inner_q = Q_SINGLE;
                end else if (c == open_ch) begin
                    if (depth >= MAX_DEPTH)
                        return 1'b0;
                    depth++;
                end else if (c == close_ch) begin
                    if (depth > 0)
                        depth--;
                    if (depth == 0)
                        mode = MODE_TOP;
                end
            end else if (inner_q == Q_SINGLE) begin
                if (c == CH_SQUOTE)
                    inner_q = Q_NONE;
            end else begin
                if (c == CH_BSLASH)
                    esc = 1'b1;
                else if (c == CH_DQUOTE)
                    inner_q = Q_NONE;
            end
            return 1'b1;
        endfunction

        function void note_byte(swt_in_t it);
            swt_out_t          r;
            logic [7:0]        c;
            logic [CODE_W-1:0] code;
            logic [7:0]        term;
            int unsigned       col;
            bit                keep;
            bit                brk;
            bit                overflow;
            r        = '0;
            c        = it.char_in;
            keep     = 1'b0;
            brk      = 1'b0;
            overflow = 1'b0;
            items++;
            if (it.is_end) begin
                lines++;
                if (!err_lat) begin
                    code = ERR_NONE;
                    col  = col_cnt;
                    case (mode)
                        MODE_CMD:   code = ERR_CMD;
                        MODE_TICK:  code = ERR_TICK;
                        MODE_DSQ:   code = ERR_DSQ;
                        MODE_BRACE: code = ERR_PARAM;
                        default:
                        begin
                            // A trailing backslash is reported at its own column.
                            if (esc) begin
                                code = ERR_BSLASH;
                                col  = col_cnt - 1;
                            end else if (outer_q != Q_NONE) begin
                                code = ERR_QUOTE;
                            end
                        end
                    endcase
                    if (code != ERR_NONE)
                        flag_error(r, code, col);
                    else
                        r.word_end = word_act;
                end
                r.line_done = 1'b1;
                clear_scan();
            end else if (!err_lat) begin
                if (esc) begin
                    esc  = 1'b0;
                    keep = 1'b1;
                end else if (mode == MODE_TOP) begin
                    if (dol) begin
                        dol = 1'b0;
                        if (c == CH_LPAREN || c == CH_LBRACE) begin
                            mode    = (c == CH_LPAREN) ? MODE_CMD : MODE_BRACE;
                            depth   = 1;
                            inner_q = Q_NONE;
                            keep    = 1'b1;
                        end else if (c == CH_SQUOTE) begin
                            mode = MODE_DSQ;
                            keep = 1'b1;
                        end else begin
                            keep = top_byte(c, brk);
                        end
                    end else begin
                        keep = top_byte(c, brk);
                    end
                end else if (mode == MODE_CMD || mode == MODE_BRACE) begin
                    if (nest_byte(c))
                        keep = 1'b1;
                    else
                        overflow = 1'b1;
                end else begin
                    term = (mode == MODE_TICK) ? CH_TICK : CH_SQUOTE;
                    if (c == CH_BSLASH)
                        esc = 1'b1;
                    else if (c == term)
                        mode = MODE_TOP;
                    keep = 1'b1;
                end
                // The overflowing bracket is dropped and does not move the position.
                if (overflow) begin
                    flag_error(r, ERR_NEST, col_cnt);
                end else begin
                    advance_pos(c);
                    if (keep) begin
                        r.char_out   = c;
                        r.char_valid = 1'b1;
                    end
                    r.word_end = brk;
                end
            end
            if (r.error_code != ERR_NONE)
                error_reports++;
            expected_tokens.push_back(r);
        endfunction

        function void compare_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
            if (exp_val !== act_val) begin
                mismatches++;
                $error("%s: expected %0h, got %0h", name, exp_val, act_val);
            end
        endfunction

        function void check_token(swt_out_t got);
            swt_out_t exp_tok;
            results++;
            if (expected_tokens.size() == 0) begin
                mismatches++;
                $error("result transfer with no prediction waiting");
                return;
            end
            exp_tok = expected_tokens.pop_front();
            compare_field("char_out", 32'(exp_tok.char_out), 32'(got.char_out));
            compare_field("char_valid", 32'(exp_tok.char_valid), 32'(got.char_valid));
            compare_field("word_end", 32'(exp_tok.word_end), 32'(got.word_end));
            compare_field("error_code", 32'(exp_tok.error_code), 32'(got.error_code));
            compare_field("error_line", 32'(exp_tok.error_line), 32'(got.error_line));
            compare_field("error_column", 32'(exp_tok.error_column),
                          32'(got.error_column));
            compare_field("line_done", 32'(exp_tok.line_done), 32'(got.line_done));
        endfunction

    endclass

endpackage

// ----- test/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: shell word tokenizer
// Feeds command lines byte by byte with random gaps and output stalls,
// changes start_line between phases and checks every result transfer
// against the scoreboard prediction.
// ----------------------------------------------------------------------------
module testbench;

    import swt_pkg::*;
    import tokenizer_tb_pkg::*;

    localparam int PHASES          = 5;
    localparam int ITEMS_PER_PHASE = 70;
    localparam int DRAIN_CYCLES    = 8;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    swt_in_t             in_data;
    logic                out_valid;
    logic                out_ready;
    swt_out_t            out_data;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    tokenizer_scoreboard sb = new();
    logic [7:0]          line_bytes[$];
    bit                  tx_idle;
    bit                  rx_idle;

    shell_word_tokenizer i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

    // Writes start_line, reads it back and updates the prediction.
    task automatic program_start_line(input logic [15:0] value);
        logic [PDATA_W-1:0] readback;
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_START_LINE;
        pwdata  <= {16'h0000, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        sb.set_start_line(value);
        @(posedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(negedge clk);
        readback = prdata;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (readback[15:0] !== value) begin
            sb.mismatches++;
            $error("start_line: expected %0h, got %0h", value, readback[15:0]);
        end
    endtask

    // Called at a rising edge; returns at the edge where the transfer happens.
    task automatic send_item(input swt_in_t it, input bit drain);
        int unsigned gap;
        gap = tx_idle ? $urandom_range(0, 4) : 0;
        if (gap > 0 || drain) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
            if (drain) begin
                do @(posedge clk); while (sb.pending() != 0);
            end
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge clk); while (!in_ready);
        sb.note_byte(it);
    endtask

    task automatic add_byte(input logic [7:0] b);
        line_bytes.push_back(b);
    endtask

    task automatic add_str(input string s);
        for (int i = 0; i < s.len(); i++)
            line_bytes.push_back(s[i]);
    endtask

    task automatic add_letters(input int lo, input int hi);
        repeat ($urandom_range(lo, hi)) add_byte(8'($urandom_range(8'h61, 8'h7a)));
    endtask

    function automatic logic [7:0] pick_blank();
        case ($urandom_range(0, 5))
            0:       return CH_SPACE;
            1:       return CH_TAB;
            2:       return CH_NL;
            3:       return CH_VT;
            4:       return CH_FF;
            default: return CH_CR;
        endcase
    endfunction

    task automatic add_inner_part();
        case ($urandom_range(0, 5))
            0, 1: add_letters(1, 3);
            2:    add_byte(pick_blank());
            3:
            begin
                add_byte(CH_SQUOTE);
                add_letters(0, 2);
                add_byte(CH_SQUOTE);
            end
            4:
            begin
                add_byte(CH_DQUOTE);
                add_letters(0, 2);
                if ($urandom_range(0, 1)) begin
                    add_byte(CH_BSLASH);
                    add_byte(CH_DQUOTE);
                end
                add_byte(CH_DQUOTE);
            end
            default:
            begin
                add_byte(CH_BSLASH);
                add_byte(8'($urandom_range(0, 255)));
            end
        endcase
    endtask

    // $( ) or ${ } with up to three levels of brackets and quoted content.
    task automatic add_subst(input bit is_cmd);
        logic [7:0] open_ch;
        logic [7:0] close_ch;
        int         levels;
        open_ch  = is_cmd ? CH_LPAREN : CH_LBRACE;
        close_ch = is_cmd ? CH_RPAREN : CH_RBRACE;
        levels   = $urandom_range(1, 3);
        add_byte(CH_DOLLAR);
        add_byte(open_ch);
        add_inner_part();
        repeat (levels - 1) begin
            add_byte(open_ch);
            add_inner_part();
        end
        repeat (levels - 1) begin
            add_inner_part();
            add_byte(close_ch);
        end
        add_byte(close_ch);
    endtask

    task automatic add_dquote();
        add_byte(CH_DQUOTE);
        repeat ($urandom_range(0, 4)) begin
            case ($urandom_range(0, 5))
                0, 1: add_letters(1, 3);
                2:
                begin
                    add_byte(CH_BSLASH);
                    add_byte(8'($urandom_range(0, 255)));
                end
                3:
                begin
                    add_byte(CH_DOLLAR);
                    add_letters(1, 2);
                end
                4:       add_byte(CH_SQUOTE);
                default: add_subst(1'($urandom_range(0, 1)));
            endcase
        end
        add_byte(CH_DQUOTE);
    endtask

    task automatic add_fragment();
        bit tick_open;
        case ($urandom_range(0, 13))
            0, 1, 2: add_letters(1, 5);
            3, 4:    add_byte(pick_blank());
            5:
            begin
                add_byte(CH_SQUOTE);
                repeat ($urandom_range(0, 4)) begin
                    case ($urandom_range(0, 5))
                        0:       add_byte(CH_DQUOTE);
                        1:       add_byte(CH_DOLLAR);
                        2:       add_byte(CH_TICK);
                        3:       add_byte(CH_BSLASH);
                        4:       add_byte(CH_SPACE);
                        default: add_letters(1, 1);
                    endcase
                end
                add_byte(CH_SQUOTE);
            end
            6:  add_dquote();
            7:  add_subst(1'b1);
            8:  add_subst(1'b0);
            9, 10:
            begin
                // Backtick or $' ', both with an optional escaped byte.
                tick_open = $urandom_range(0, 1) != 0;
                if (tick_open) begin
                    add_byte(CH_TICK);
                end else begin
                    add_byte(CH_DOLLAR);
                    add_byte(CH_SQUOTE);
                end
                add_letters(0, 3);
                if ($urandom_range(0, 1)) begin
                    add_byte(CH_BSLASH);
                    add_byte(8'($urandom_range(0, 255)));
                end
                add_letters(0, 2);
                add_byte(tick_open ? CH_TICK : CH_SQUOTE);
            end
            11:
            begin
                add_byte(CH_BSLASH);
                add_byte(8'($urandom_range(0, 255)));
            end
            12: add_byte(8'($urandom_range(0, 255)));
            default:
            begin
                add_byte(CH_DOLLAR);
                if ($urandom_range(0, 1))
                    add_byte(pick_blank());
            end
        endcase
    endtask

    // Sends the collected bytes, optionally truncated, followed by the end marker.
    task automatic send_line(input bit truncate);
        swt_in_t     it;
        int unsigned keep_len;
        if (truncate && line_bytes.size() > 1) begin
            keep_len = $urandom_range(1, line_bytes.size() - 1);
            while (line_bytes.size() > keep_len)
                void'(line_bytes.pop_back());
        end
        foreach (line_bytes[i]) begin
            it.char_in = line_bytes[i];
            it.is_end  = 1'b0;
            send_item(it, $urandom_range(0, 79) == 0);
        end
        it.char_in = 8'($urandom_range(0, 255));
        it.is_end  = 1'b1;
        send_item(it, 1'b0);
        line_bytes.delete();
    endtask

    task automatic send_random_line();
        tx_idle = $urandom_range(0, 3) != 0;
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 12)) add_byte(8'($urandom_range(0, 255)));
        end else begin
            repeat ($urandom_range(1, 8)) add_fragment();
        end
        send_line($urandom_range(0, 4) == 0);
    endtask

    // Brackets up to the nesting limit, one more that overflows, then bytes
    // that must be ignored until the end marker.
    task automatic send_deep_line(input bit is_cmd);
        logic [7:0] open_ch;
        open_ch = is_cmd ? CH_LPAREN : CH_LBRACE;
        tx_idle = 1'b0;
        add_str("w");
        add_byte(CH_DOLLAR);
        add_byte(open_ch);
        repeat (MAX_DEPTH) add_byte(open_ch);
        repeat (3) add_byte(8'($urandom_range(0, 255)));
        send_line(1'b0);
    endtask

    initial
    begin
        int unsigned target;
        logic [15:0] settings[PHASES];
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        paddr     <= '0;
        pwdata    <= '0;
        tx_idle    = 1'b1;
        settings   = '{16'd0, 16'hFFFF, 16'd1, 16'($urandom_range(2, 65534)),
                       16'($urandom_range(0, 65535))};
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        for (int p = 0; p < PHASES; p++) begin
            // start_line changes only with the pipeline empty.
            in_valid <= 1'b0;
            while (sb.pending() != 0) @(posedge clk);
            program_start_line(settings[p]);
            if (p == 0) begin
                add_str("x\\");
                send_line(1'b0);
                add_str("$(");
                add_byte(8'h00);
                send_line(1'b0);
                add_str("`b");
                send_line(1'b0);
                add_str("$'c");
                send_line(1'b0);
                add_str("${d");
                send_line(1'b0);
                add_str("'");
                add_byte(8'hFF);
                send_line(1'b0);
                add_str("$ a");
                send_line(1'b0);
            end
            if (p == 2)
                send_deep_line(1'b1);
            if (p == 3)
                send_deep_line(1'b0);
            target = sb.items + ITEMS_PER_PHASE;
            while (sb.items < target)
                send_random_line();
        end

        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d input transfers in %0d lines with %0d error reports,",
                 sb.items, sb.lines, sb.error_reports);
        $display("over %0d start_line settings including 0, 1 and 65535.", PHASES);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial
    begin
        int unsigned gap;
        out_ready <= 1'b0;
        rx_idle    = 1'b1;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            if (sb.results % 32 == 0)
                rx_idle = $urandom_range(0, 3) != 0;
            gap = rx_idle ? $urandom_range(0, 4) : 0;
            if (gap > 0) begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            sb.check_token(out_data);
        end
    end

endmodule

// ----- shell_word_tokenizer.f -----
hw/rtl/swt_pkg.sv
hw/rtl/swt_front.sv
hw/rtl/swt_queue.sv
hw/rtl/swt_back.sv
hw/rtl/shell_word_tokenizer.sv
hw/rtl/swt_checker.sv
test/tokenizer_tb_pkg.sv
test/testbench.sv
